### rtl/pwm_tone_divider_calc_unit_macros.svh
// ----------------------------------------------------------------------------
// pwm tone divider calc unit assertion macros
// shared concurrent assertion forms, clocked on clk with async reset disable
// ----------------------------------------------------------------------------
`ifndef PWM_TONE_DIVIDER_CALC_UNIT_MACROS_SVH
`define PWM_TONE_DIVIDER_CALC_UNIT_MACROS_SVH

// same-cycle implication
`define PTDC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ptdc assertion failed");

// next-cycle implication
`define PTDC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ptdc assertion failed");

`endif

### rtl/ptdc_pkg.sv
// ----------------------------------------------------------------------------
// ptdc_pkg
// types and constants of the pwm tone divider calc unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptdc_pkg;

	localparam int CLK_W   = 28;
	localparam int TONE_W  = 20;
	localparam int DIV_W   = 12;
	localparam int WRAP_W  = 16;
	localparam int WORK_W  = 32;
	localparam int CNT_W   = 5;

	localparam logic [CLK_W-1:0]  SYS_CLK_RESET = 28'd125000000;
	localparam logic [WRAP_W-1:0] MAX_WRAP_DEF  = 16'd65534;

	// q thresholds, 16 times the factor
	localparam logic [WORK_W-1:0] Q_MIN_5   = 32'd80;
	localparam logic [WORK_W-1:0] Q_MIN_3   = 32'd48;
	localparam logic [WORK_W-1:0] Q_MIN_2   = 32'd32;
	localparam logic [WORK_W-1:0] Q_LOW     = 32'd16;
	localparam logic [WORK_W-1:0] Q_HIGH    = 32'd4096;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DIV    = 5'b00010,
		ST_FACT   = 5'b00100,
		ST_DECIDE = 5'b01000,
		ST_SPARE  = 5'b10000
	} state_t;

endpackage

### rtl/pwm_tone_divider_calc_unit.sv
// ----------------------------------------------------------------------------
// pwm tone divider calc unit
// bit-serial 16*clk/tone division, then serial factor 5/3/2 moves into wrap
// ----------------------------------------------------------------------------
// a zero tone is answered straight from idle; else the division runs, then a pass of
// the serial /5 and /3 unit and a decide step, repeated after each move (at most 15)
// throughput: one request at a time, busy is high until done has fired
// results are shown with done and held until the next result; the receiver cannot stall
// reset: arst_n clears control state and loads sys_clk_q with 125000000
`timescale 1ns / 1ps

`include "pwm_tone_divider_calc_unit_macros.svh"

module pwm_tone_divider_calc_unit #(
	parameter logic [ptdc_pkg::WRAP_W-1:0] MAX_WRAP = ptdc_pkg::MAX_WRAP_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ptdc_pkg::CLK_W-1:0]     cfg_data,
	input  logic                           start,
	output logic                           busy,
	input  logic [ptdc_pkg::TONE_W-1:0]    tone_hz,
	output logic                           done,
	output logic                           valid_res,
	output logic [ptdc_pkg::DIV_W-1:0]     clock_divider,
	output logic [ptdc_pkg::WRAP_W-1:0]    wrap_value
);

	ptdc_pkg::state_t state_q;

	logic [ptdc_pkg::CLK_W-1:0]   sys_clk_q;
	logic [ptdc_pkg::TONE_W-1:0]  hz_q;
	logic [ptdc_pkg::TONE_W-1:0]  rem_q;
	logic [ptdc_pkg::WORK_W-1:0]  work_q;
	logic [ptdc_pkg::WORK_W-1:0]  q5_q;
	logic [ptdc_pkg::WORK_W-1:0]  q3_q;
	logic [2:0]                   r5_q;
	logic [1:0]                   r3_q;
	logic [ptdc_pkg::WRAP_W-1:0]  wrap_q;
	logic [ptdc_pkg::CNT_W-1:0]   cnt_q;

	logic                         done_q;
	logic                         valid_q;
	logic [ptdc_pkg::DIV_W-1:0]   div_q;
	logic [ptdc_pkg::WRAP_W-1:0]  wrap_out_q;

	// division step
	logic [ptdc_pkg::TONE_W:0]    rem_sh;
	logic [ptdc_pkg::TONE_W:0]    rem_sub;
	logic                         div_bit;

	// serial constant dividers
	logic [3:0]                   t5;
	logic [2:0]                   t3;
	logic                         ge5;
	logic                         ge3;
	logic [3:0]                   t5_sub;
	logic [2:0]                   t3_sub;

	// factor checks
	logic [ptdc_pkg::WRAP_W+2:0]  wrap5;
	logic [ptdc_pkg::WRAP_W+2:0]  wrap3;
	logic [ptdc_pkg::WRAP_W+2:0]  wrap2;
	logic [ptdc_pkg::WRAP_W+2:0]  max_ext;
	logic                         mv5;
	logic                         mv3;
	logic                         mv2;
	logic                         q_ok;

	always_comb begin
		rem_sh  = {rem_q, work_q[ptdc_pkg::WORK_W-1]};
		rem_sub = rem_sh - {1'b0, hz_q};
		div_bit = (rem_sh >= {1'b0, hz_q});

		t5     = {r5_q, work_q[ptdc_pkg::WORK_W-1]};
		t3     = {r3_q, work_q[ptdc_pkg::WORK_W-1]};
		ge5    = (t5 >= 4'd5);
		ge3    = (t3 >= 3'd3);
		t5_sub = t5 - 4'd5;
		t3_sub = t3 - 3'd3;

		max_ext = {3'b000, MAX_WRAP};
		wrap5   = {3'b000, wrap_q} * 19'd5;
		wrap3   = {3'b000, wrap_q} * 19'd3;
		wrap2   = {2'b00, wrap_q, 1'b0};
		mv5     = (work_q >= ptdc_pkg::Q_MIN_5) && (r5_q == 3'd0) && (wrap5 <= max_ext);
		mv3     = (work_q >= ptdc_pkg::Q_MIN_3) && (r3_q == 2'd0) && (wrap3 <= max_ext);
		mv2     = (work_q >= ptdc_pkg::Q_MIN_2) && (wrap2 <= max_ext);
		q_ok    = (work_q >= ptdc_pkg::Q_LOW) && (work_q < ptdc_pkg::Q_HIGH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sys_clk_q <= ptdc_pkg::SYS_CLK_RESET;
		end else if (cfg_we) begin
			sys_clk_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptdc_pkg::ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ptdc_pkg::ST_IDLE: begin
					if (start) begin
						if (tone_hz == '0) begin
							done_q  <= 1'b1;
							valid_q <= 1'b0;
						end else begin
							state_q <= ptdc_pkg::ST_DIV;
						end
					end
					cnt_q <= '0;
				end
				ptdc_pkg::ST_DIV: begin
					cnt_q <= cnt_q + ptdc_pkg::CNT_W'(1);
					if (cnt_q == '1) begin
						state_q <= ptdc_pkg::ST_FACT;
					end
				end
				ptdc_pkg::ST_FACT: begin
					cnt_q <= cnt_q + ptdc_pkg::CNT_W'(1);
					if (cnt_q == '1) begin
						state_q <= ptdc_pkg::ST_DECIDE;
					end
				end
				ptdc_pkg::ST_DECIDE: begin
					cnt_q <= '0;
					if (mv5 || mv3 || mv2) begin
						state_q <= ptdc_pkg::ST_FACT;
					end else begin
						state_q <= ptdc_pkg::ST_IDLE;
						done_q  <= 1'b1;
						valid_q <= q_ok;
					end
				end
				default: begin
					state_q <= ptdc_pkg::ST_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ptdc_pkg::ST_IDLE: begin
				hz_q   <= tone_hz;
				rem_q  <= '0;
				work_q <= {sys_clk_q, 4'b0000};
				if (start && (tone_hz == '0)) begin
					div_q      <= '0;
					wrap_out_q <= '0;
				end
			end
			ptdc_pkg::ST_DIV: begin
				rem_q  <= div_bit ? rem_sub[ptdc_pkg::TONE_W-1:0] : rem_sh[ptdc_pkg::TONE_W-1:0];
				work_q <= {work_q[ptdc_pkg::WORK_W-2:0], div_bit};
				wrap_q <= {{(ptdc_pkg::WRAP_W-1){1'b0}}, 1'b1};
				r5_q   <= '0;
				r3_q   <= '0;
			end
			ptdc_pkg::ST_FACT: begin
				work_q <= {work_q[ptdc_pkg::WORK_W-2:0], work_q[ptdc_pkg::WORK_W-1]};
				q5_q   <= {q5_q[ptdc_pkg::WORK_W-2:0], ge5};
				q3_q   <= {q3_q[ptdc_pkg::WORK_W-2:0], ge3};
				r5_q   <= ge5 ? t5_sub[2:0] : t5[2:0];
				r3_q   <= ge3 ? t3_sub[1:0] : t3[1:0];
			end
			ptdc_pkg::ST_DECIDE: begin
				r5_q <= '0;
				r3_q <= '0;
				if (mv5) begin
					work_q <= q5_q;
					wrap_q <= wrap5[ptdc_pkg::WRAP_W-1:0];
				end else if (mv3) begin
					work_q <= q3_q;
					wrap_q <= wrap3[ptdc_pkg::WRAP_W-1:0];
				end else if (mv2) begin
					work_q <= {1'b0, work_q[ptdc_pkg::WORK_W-1:1]};
					wrap_q <= wrap2[ptdc_pkg::WRAP_W-1:0];
				end else begin
					div_q      <= q_ok ? work_q[ptdc_pkg::DIV_W-1:0] : '0;
					wrap_out_q <= q_ok ? wrap_q : '0;
				end
			end
			default: begin
				rem_q <= '0;
			end
		endcase
	end

	assign busy          = (state_q != ptdc_pkg::ST_IDLE);
	assign done          = done_q;
	assign valid_res     = valid_q;
	assign clock_divider = div_q;
	assign wrap_value    = wrap_out_q;

	`PTDC_ASSERT_NEXT(a_start_busy, start && !busy && (tone_hz != '0), busy)
	`PTDC_ASSERT_NEXT(a_done_single, done && !(start && (tone_hz == '0)), !done)
	`PTDC_ASSERT_SAME(a_invalid_zero, done && !valid_res, (clock_divider == '0) && (wrap_value == '0))
	`PTDC_ASSERT_SAME(a_valid_div_min, done && valid_res, (clock_divider >= 12'd16) && (wrap_value != '0))
	`PTDC_ASSERT_SAME(a_wrap_bound, state_q == ptdc_pkg::ST_DECIDE, (wrap_q != '0) && (wrap_q <= MAX_WRAP))

endmodule
